FILE: hdl/qgram_skip_search_counter_unit_defines.svh
// assertion helpers, clocked on i_clk, off during reset
`ifndef QGRAM_SKIP_SEARCH_COUNTER_UNIT_DEFINES_SVH
`define QGRAM_SKIP_SEARCH_COUNTER_UNIT_DEFINES_SVH

`define QSS_ASSERT_NOW(lbl, a, c) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (c)) \
        else $error("assertion failed");

`define QSS_ASSERT_NEXT(lbl, a, c) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (c)) \
        else $error("assertion failed");

`endif

FILE: hdl/qss_pkg.sv
`default_nettype none
package qss_pkg;
    localparam int MAX_PATTERN = 256;
    localparam int MAX_TEXT    = 4096;
    localparam int HASH_BUCKETS = 32768;
    localparam int GRAM        = 7;

    typedef enum logic [3:0] {
        S_LOAD, S_CLR, S_PRD, S_PSH, S_PLK, S_WIN, S_TRD, S_TSH,
        S_HRD, S_NODE, S_CHN, S_VRD, S_VCMP, S_OUT
    } t_state;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SHORT = 2'd1;
    localparam logic [1:0] ST_OVF   = 2'd2;

    typedef logic [7:0] t_gram [GRAM];

    function automatic logic [14:0] gram_hash(input t_gram g);
        logic [14:0] h;
        h = '0;
        for (int k = 0; k < GRAM; k++) begin
            h = h + (15'({7'd0, g[k]}) << (GRAM - 1 - k));
        end
        return h;
    endfunction
endpackage
`default_nettype wire

FILE: hdl/qgram_skip_search_counter_unit.sv
// qgram_skip_search_counter_unit
// Input channel (i_in_valid/o_in_ready): one byte per request, i_action 0 for
// a pattern byte, 1 for a text byte, i_last closes a pattern or a text.
// Loading takes one request per cycle while the block is loading.
// The text request with i_last starts a search; no requests are taken until
// it ends. The search first clears all 32768 bucket heads, then reads the
// pattern byte by byte into a 7-byte gram and, from the seventh byte on, hashes
// it into its bucket; then for each text window it reads 7 text bytes and its
// bucket head, walks the bucket's entries and verifies each candidate byte by
// byte. All memories are read through an output register.
// Output channel (o_out_valid/i_out_ready): one request per search with
// o_match_count and o_status. The result sits in an output register; loading
// continues while it waits, and the next search holds its result until the
// receiver takes the old one.
// Reset (synchronous, i_rst_n low) empties the lengths, flags and output.
// A pattern under 7 bytes answers status 1 without a search; o_out_valid
// rises once the result passes S_OUT into the output register.
`default_nettype none
`include "qgram_skip_search_counter_unit_defines.svh"
module qgram_skip_search_counter_unit
    import qss_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_action,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [12:0]      o_match_count,
    output logic [1:0]       o_status
);
    logic [7:0] pmem [MAX_PATTERN];
    logic [7:0] tmem [MAX_TEXT];
    logic [8:0] hmem [HASH_BUCKETS];
    logic [8:0] cmem [MAX_PATTERN];

    t_state r_state, n_state;
    logic [8:0]  r_pat_len;
    logic [12:0] r_txt_len;
    logic        r_ovf, r_povf, r_popen, r_topen;
    logic [7:0]  r_pq, r_tq;
    logic [8:0]  r_hq, r_cq;
    t_gram       r_gram, n_gram;
    logic [7:0]  r_k, n_k;
    logic [14:0] r_h, n_h;
    logic [13:0] r_j, n_j;
    logic [8:0]  r_node, n_node;
    logic [11:0] r_start, n_start;
    logic [12:0] r_cnt, n_cnt;
    logic [14:0] r_clr, n_clr;
    logic [1:0]  r_sts, n_sts;
    logic        r_oval;
    logic [12:0] r_ocnt;
    logic [1:0]  r_osts;
    logic        out_load;

    logic [7:0]  pa;
    logic [11:0] ta;
    logic [14:0] ha;
    logic [7:0]  ca;
    logic        hwe, cwe;
    logic [14:0] hwa;
    logic [8:0]  hwd;
    logic [7:0]  cwa;
    logic [8:0]  cwd;

    logic        acc;
    logic [8:0]  p_len_eff;
    logic [12:0] t_len_eff;
    logic        t_ovf_new;
    logic [8:0]  mq;
    logic [7:0]  e;
    logic [12:0] start_full;
    logic [14:0] hash_now;
    logic [8:0]  km1;

    assign o_in_ready = (r_state == S_LOAD);
    assign acc = i_in_valid && o_in_ready;
    assign p_len_eff = r_popen ? r_pat_len : 9'd0;
    assign t_len_eff = r_topen ? r_txt_len : 13'd0;
    assign t_ovf_new = (r_topen && r_ovf) || (t_len_eff == 13'(MAX_TEXT));
    assign mq = r_pat_len - 9'd6;
    assign e = 8'(r_node - 9'd1);
    assign start_full = r_j[12:0] - {5'd0, e};
    assign km1 = r_pat_len - 9'd1;

    // load side
    always_ff @(posedge i_clk) begin
        if (acc && !i_action && p_len_eff < 9'(MAX_PATTERN)) begin
            pmem[p_len_eff[7:0]] <= i_data_byte;
        end
        if (acc && i_action && t_len_eff < 13'(MAX_TEXT)) begin
            tmem[t_len_eff[11:0]] <= i_data_byte;
        end
        r_pq <= pmem[pa];
        r_tq <= tmem[ta];
    end

    always_ff @(posedge i_clk) begin
        if (hwe) begin
            hmem[hwa] <= hwd;
        end
        if (cwe) begin
            cmem[cwa] <= cwd;
        end
        r_hq <= hmem[ha];
        r_cq <= cmem[ca];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_len <= '0;
            r_txt_len <= '0;
            r_ovf     <= 1'b0;
            r_povf    <= 1'b0;
            r_popen   <= 1'b0;
            r_topen   <= 1'b0;
        end else if (acc) begin
            if (!i_action) begin
                r_popen <= !i_last;
                if (p_len_eff < 9'(MAX_PATTERN)) begin
                    r_pat_len <= p_len_eff + 9'd1;
                    r_povf    <= r_popen && r_povf;
                end else begin
                    r_pat_len <= p_len_eff;
                    r_povf    <= 1'b1;
                end
            end else begin
                r_topen <= !i_last;
                r_ovf   <= t_ovf_new;
                if (t_len_eff < 13'(MAX_TEXT)) begin
                    r_txt_len <= t_len_eff + 13'd1;
                end else begin
                    r_txt_len <= t_len_eff;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_oval <= 1'b1;
            end else if (i_out_ready) begin
                r_oval <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state inside {S_PSH, S_TSH}) begin
            r_gram <= n_gram;
        end
        r_k     <= n_k;
        r_h     <= n_h;
        r_j     <= n_j;
        r_node  <= n_node;
        r_start <= n_start;
        r_cnt   <= n_cnt;
        r_clr   <= n_clr;
        r_sts   <= n_sts;
        if (out_load) begin
            r_ocnt <= r_cnt;
            r_osts <= r_sts;
        end
    end

    always_comb begin
        for (int k = 0; k < GRAM - 1; k++) begin
            n_gram[k] = r_gram[k + 1];
        end
        n_gram[GRAM - 1] = (r_state == S_PSH) ? r_pq : r_tq;
        hash_now = gram_hash(n_gram);
    end

    always_comb begin
        n_state  = r_state;
        n_k      = r_k;
        n_h      = r_h;
        n_j      = r_j;
        n_node   = r_node;
        n_start  = r_start;
        n_cnt    = r_cnt;
        n_clr    = r_clr;
        n_sts    = r_sts;
        out_load = 1'b0;
        pa  = r_k;
        ta  = r_j[11:0] + {4'd0, r_k};
        ha  = r_h;
        ca  = e;
        hwe = 1'b0;
        hwa = r_clr;
        hwd = '0;
        cwe = 1'b0;
        cwa = r_k - 8'd6;
        cwd = r_hq;
        case (r_state)
            S_LOAD: begin
                if (acc && i_action && i_last) begin
                    n_cnt = '0;
                    n_clr = '0;
                    if (r_pat_len < 9'(GRAM)) begin
                        n_sts   = ST_SHORT;
                        n_state = S_OUT;
                    end else begin
                        n_sts   = (t_ovf_new || r_povf) ? ST_OVF : ST_OK;
                        n_state = S_CLR;
                    end
                end
            end
            S_CLR: begin
                hwe   = 1'b1;
                n_clr = r_clr + 15'd1;
                if (r_clr == 15'(HASH_BUCKETS - 1)) begin
                    n_k     = '0;
                    n_state = S_PRD;
                end
            end
            S_PRD: begin
                n_state = S_PSH;
            end
            S_PSH: begin
                if (r_k >= 8'd6) begin
                    ha      = hash_now;
                    n_h     = hash_now;
                    n_state = S_PLK;
                end else begin
                    n_k     = r_k + 8'd1;
                    n_state = S_PRD;
                end
            end
            S_PLK: begin
                cwe = 1'b1;
                hwe = 1'b1;
                hwa = r_h;
                hwd = {1'b0, r_k} - 9'd5;
                n_k = r_k + 8'd1;
                if ({1'b0, r_k} == km1) begin
                    n_j     = {5'd0, mq} - 14'd1;
                    n_state = S_WIN;
                end else begin
                    n_state = S_PRD;
                end
            end
            S_WIN: begin
                n_k = '0;
                if (r_j + 14'd7 <= {1'b0, r_txt_len}) begin
                    n_state = S_TRD;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_TRD: begin
                n_state = S_TSH;
            end
            S_TSH: begin
                if (r_k == 8'd6) begin
                    ha      = hash_now;
                    n_state = S_HRD;
                end else begin
                    n_k     = r_k + 8'd1;
                    n_state = S_TRD;
                end
            end
            S_HRD: begin
                n_node  = r_hq;
                n_state = S_NODE;
            end
            S_NODE: begin
                if (r_node == 9'd0) begin
                    n_j     = r_j + {5'd0, mq};
                    n_state = S_WIN;
                end else begin
                    n_state = S_CHN;
                end
            end
            S_CHN: begin
                n_node = r_cq;
                n_k    = '0;
                if ({1'b0, start_full} + {5'd0, r_pat_len} <= {1'b0, r_txt_len}) begin
                    n_start = start_full[11:0];
                    n_state = S_VRD;
                end else begin
                    n_state = S_NODE;
                end
            end
            S_VRD: begin
                ta      = r_start + {4'd0, r_k};
                n_state = S_VCMP;
            end
            S_VCMP: begin
                if (r_pq != r_tq) begin
                    n_state = S_NODE;
                end else if ({1'b0, r_k} == km1) begin
                    n_cnt   = r_cnt + 13'd1;
                    n_state = S_NODE;
                end else begin
                    n_k     = r_k + 8'd1;
                    n_state = S_VRD;
                end
            end
            S_OUT: begin
                if (!r_oval || i_out_ready) begin
                    out_load = 1'b1;
                    n_state  = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    assign o_out_valid   = r_oval;
    assign o_match_count = r_ocnt;
    assign o_status      = r_osts;

    `QSS_ASSERT_NOW(a_cnt_bound, r_state == S_VCMP, r_cnt <= r_txt_len)
    `QSS_ASSERT_NOW(a_verify_in_text, r_state == S_VRD,
        {1'b0, r_start} + {5'd0, r_k} < r_txt_len)
    `QSS_ASSERT_NEXT(a_no_accept_in_search, r_state == S_LOAD && acc && i_action && i_last,
        !o_in_ready)
    `QSS_ASSERT_NOW(a_short_zero, out_load && r_sts == ST_SHORT, r_cnt == 13'd0)
endmodule
`default_nettype wire
